// File: rtl/rrs_pkg.sv
// ----------------------------------------------------------------------------
// rrs_pkg
// Shared types and constants for the reset recovery sequencer.
// ----------------------------------------------------------------------------
package rrs_pkg;

  // Sequencer phase codes, numbered densely.
  localparam int unsigned PhaseW = 4;
  localparam logic [PhaseW-1:0] PH_RESET     = 4'd0;
  localparam logic [PhaseW-1:0] PH_IDLE      = 4'd1;
  localparam logic [PhaseW-1:0] PH_ASSERT    = 4'd2;
  localparam logic [PhaseW-1:0] PH_HOLD      = 4'd3;
  localparam logic [PhaseW-1:0] PH_RELEASE   = 4'd4;
  localparam logic [PhaseW-1:0] PH_STABILIZE = 4'd5;
  localparam logic [PhaseW-1:0] PH_VERIFY    = 4'd6;
  localparam logic [PhaseW-1:0] PH_COMPLETE  = 4'd7;
  localparam logic [PhaseW-1:0] PH_FAILED    = 4'd8;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_CYCLES      = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_STABILIZE_CYCLES = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_READY_TIMEOUT    = 2'd2;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned DelayW   = 17;

  localparam logic [CfgDataW-1:0] HOLD_RESET      = 16'd16;
  localparam logic [CfgDataW-1:0] STABILIZE_RESET = 16'd32;
  localparam logic [CfgDataW-1:0] TIMEOUT_RESET   = 16'd1000;

  typedef struct packed {
    logic sync_reset;
    logic start_request;
    logic sys_ready;
  } in_beat_t;

  typedef struct packed {
    logic              reset_req;
    logic              busy_res;
    logic              done_res;
    logic              failed;
    logic [PhaseW-1:0] state_code;
  } out_beat_t;

  typedef struct packed {
    logic [CfgDataW-1:0] hold_cycles;
    logic [CfgDataW-1:0] stabilize_cycles;
    logic [CfgDataW-1:0] ready_timeout;
  } cfg_t;

endpackage

// File: rtl/rrs_cfg_regs.sv
// ----------------------------------------------------------------------------
// rrs_cfg_regs
// Configuration register file for the sequencer's three timing lengths.
// ----------------------------------------------------------------------------
module rrs_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [rrs_pkg::CfgIdxW-1:0]   wr_index_i,
  input  logic [rrs_pkg::CfgDataW-1:0]  wr_data_i,
  output rrs_pkg::cfg_t                 cfg_o
);
  import rrs_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        CFG_HOLD_CYCLES:      cfg_d.hold_cycles      = wr_data_i;
        CFG_STABILIZE_CYCLES: cfg_d.stabilize_cycles = wr_data_i;
        CFG_READY_TIMEOUT:    cfg_d.ready_timeout    = wr_data_i;
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_cycles      <= HOLD_RESET;
      cfg_q.stabilize_cycles <= STABILIZE_RESET;
      cfg_q.ready_timeout    <= TIMEOUT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/rrs_seq_core.sv
// ----------------------------------------------------------------------------
// rrs_seq_core
// Phase register, delay and timeout counters and the one-tick transition.
// ----------------------------------------------------------------------------
module rrs_seq_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  rrs_pkg::in_beat_t  tick_i,
  input  rrs_pkg::cfg_t      cfg_i,
  output rrs_pkg::out_beat_t res_o
);
  import rrs_pkg::*;

  logic [PhaseW-1:0]   phase_q, phase_d;
  logic [DelayW-1:0]   delay_q, delay_d;
  logic [CfgDataW-1:0] tmo_q, tmo_d;
  logic [CfgDataW-1:0] limit;
  logic [DelayW-1:0]   delay_inc;
  logic [CfgDataW-1:0] tmo_inc;

  // A timeout of zero behaves as one.
  assign limit     = (cfg_i.ready_timeout == '0) ? CfgDataW'(1) : cfg_i.ready_timeout;
  assign delay_inc = delay_q + DelayW'(1);
  assign tmo_inc   = tmo_q + CfgDataW'(1);

  always_comb begin
    phase_d = phase_q;
    delay_d = delay_q;
    tmo_d   = tmo_q;
    if (tick_i.sync_reset) begin
      phase_d = PH_RESET;
      delay_d = '0;
      tmo_d   = '0;
    end else begin
      unique case (phase_q)
        PH_RESET: begin
          delay_d = '0;
          tmo_d   = '0;
          phase_d = PH_IDLE;
        end
        PH_IDLE: begin
          delay_d = '0;
          tmo_d   = '0;
          if (tick_i.start_request) phase_d = PH_ASSERT;
        end
        PH_ASSERT: begin
          delay_d = DelayW'(1);
          phase_d = (cfg_i.hold_cycles == '0) ? PH_RELEASE : PH_HOLD;
        end
        PH_HOLD: begin
          delay_d = delay_inc;
          if (delay_inc >= {1'b0, cfg_i.hold_cycles}) phase_d = PH_RELEASE;
        end
        PH_RELEASE: begin
          delay_d = DelayW'(1);
          phase_d = (cfg_i.stabilize_cycles == '0) ? PH_VERIFY : PH_STABILIZE;
        end
        PH_STABILIZE: begin
          delay_d = delay_inc;
          if (delay_inc > {1'b0, cfg_i.stabilize_cycles}) begin
            tmo_d   = '0;
            phase_d = PH_VERIFY;
          end
        end
        PH_VERIFY: begin
          if (tick_i.sys_ready) begin
            delay_d = '0;
            phase_d = PH_COMPLETE;
          end else begin
            tmo_d = tmo_inc;
            if (tmo_inc == limit) begin
              delay_d = '0;
              phase_d = PH_FAILED;
            end
          end
        end
        PH_COMPLETE, PH_FAILED: begin
          delay_d = '0;
          tmo_d   = '0;
          phase_d = PH_IDLE;
        end
        default: phase_d = PH_RESET;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RESET;
      delay_q <= '0;
      tmo_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      delay_q <= delay_d;
      tmo_q   <= tmo_d;
    end
  end

  // The result reflects the phase after this tick's update.
  always_comb begin
    res_o.reset_req  = (phase_d == PH_ASSERT) || (phase_d == PH_HOLD);
    res_o.busy_res   = (phase_d != PH_IDLE) && (phase_d != PH_RESET);
    res_o.done_res   = (phase_d == PH_COMPLETE);
    res_o.failed     = (phase_d == PH_FAILED);
    res_o.state_code = phase_d;
  end

endmodule

// File: rtl/reset_recovery_sequencer_unit.sv
// ----------------------------------------------------------------------------
// reset_recovery_sequencer_unit
// Nine-phase reset recovery sequencer, one input beat per sequencer tick.
// ----------------------------------------------------------------------------
// Each input beat is one tick of the sequencer and yields exactly one output
// beat carrying the reset request, busy, done, failed and the phase code as
// they stand after that tick. A beat is captured in an input register; once the
// output register is free, the phase register, the 17-bit delay counter and the
// 16-bit timeout counter are updated by one pass of the transition logic while
// the result is written to the output register. The block sustains one beat per
// clock unless stalled from downstream, which is the only thing that slows it.
// The three timing lengths are written through the configuration channel,
// which is always ready, and should only be changed while no beat is in flight.
// ----------------------------------------------------------------------------
module reset_recovery_sequencer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input beats
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rrs_pkg::in_beat_t             in_data_i,
  // Result beats
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rrs_pkg::out_beat_t            out_data_o,
  // Configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rrs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rrs_pkg::CfgDataW-1:0]  cfg_data_i
);
  import rrs_pkg::*;

  cfg_t      cfg;
  in_beat_t  in_q;
  logic      in_valid_q;
  out_beat_t out_q;
  logic      out_valid_q;
  out_beat_t res;
  logic      out_free;
  logic      step;
  logic      in_take;

  assign cfg_ready_o = 1'b1;

  rrs_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // The output register can take a new result when it is empty or being read.
  assign out_free   = !out_valid_q || !out_stall_i;
  // The held beat makes its tick when the result has somewhere to go.
  assign step       = in_valid_q && out_free;
  // The input register is free when empty or when its beat moves on.
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  rrs_seq_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .tick_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
